// File: rtl/ksca_pkg.sv
`default_nettype none
package ksca_pkg;

  typedef enum logic [2:0] {
    OP_CONNECT    = 3'd0,
    OP_RESPONSE   = 3'd1,
    OP_CHALLENGE  = 3'd2,
    OP_TICK       = 3'd3,
    OP_DISCONNECT = 3'd4
  } op_t;

  localparam logic [2:0] CFG_KEY0    = 3'd0;
  localparam logic [2:0] CFG_KEY1    = 3'd1;
  localparam logic [2:0] CFG_KEY2    = 3'd2;
  localparam logic [2:0] CFG_KEY3    = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT = 3'd4;

  localparam logic [15:0] TIMEOUT_RESET = 16'(10 * 1000);
  localparam int unsigned MSG_BYTES = 32;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] payload_w0;
    logic [63:0] payload_w1;
    logic [63:0] payload_w2;
    logic [63:0] payload_w3;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_w0;
    logic [63:0] digest_w1;
    logic [63:0] digest_w2;
    logic [63:0] digest_w3;
    logic        is_authenticated;
    logic        drop_link;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // load message block, init hash state
    logic round;  // run one compression round
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_round;
  } dp_sts_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ksca_sha_dp.sv
`default_nettype none
module ksca_sha_dp (
  input  wire logic               clk,
  input  wire ksca_pkg::dp_cmd_t  cmd,
  input  wire logic [255:0]       msg,
  output ksca_pkg::dp_sts_t       sts,
  output logic [255:0]            digest
);

  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [5:0]  rnd_r;

  logic [31:0] s0, s1, w_new, e1, ch, t1, a0, mj, t2, wcur;
  logic [7:0]  blk [64];

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      if (i < ksca_pkg::MSG_BYTES) blk[i] = msg[8*i +: 8];
      else if (i == ksca_pkg::MSG_BYTES) blk[i] = 8'h80;
      else if (i == 62) blk[i] = 8'h01;
      else blk[i] = 8'h00;
    end
  end

  always_comb begin
    wcur  = w_r[0];
    s0    = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    s1    = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
            ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    e1 = {v_r[4][5:0], v_r[4][31:6]} ^ {v_r[4][10:0], v_r[4][31:11]}
         ^ {v_r[4][24:0], v_r[4][31:25]};
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + e1 + ch + ksca_pkg::round_k(rnd_r) + wcur;
    a0 = {v_r[0][1:0], v_r[0][31:2]} ^ {v_r[0][12:0], v_r[0][31:13]}
         ^ {v_r[0][21:0], v_r[0][31:22]};
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = a0 + mj;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 16; i++)
        w_r[i] <= {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 0; i < 8; i++) v_r[i] <= ksca_pkg::init_h(3'(i));
      rnd_r <= '0;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      rnd_r <= rnd_r + 6'd1;
    end
  end

  assign sts.last_round = (rnd_r == 6'd63);

  always_comb begin
    logic [31:0] h;
    for (int j = 0; j < 8; j++) begin
      h = ksca_pkg::init_h(3'(j)) + v_r[j];
      for (int b = 0; b < 4; b++) digest[8*(4*j+b) +: 8] = h[8*(3-b) +: 8];
    end
  end

endmodule
`default_nettype wire

// File: rtl/ksca_ctrl.sv
`default_nettype none
module ksca_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ksca_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ksca_pkg::out_item_t       out_data,
  input  wire logic [255:0]         key,
  input  wire logic [15:0]          timeout,
  output ksca_pkg::dp_cmd_t         cmd,
  output logic [255:0]              msg,
  input  wire ksca_pkg::dp_sts_t    sts,
  input  wire logic [255:0]         digest
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_HASH = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [255:0] chal_r;
  logic [255:0] pay_r;
  logic [2:0]   op_r;
  logic         auth_r, link_r;
  logic [15:0]  elapsed_r;
  logic         out_valid_r;
  ksca_pkg::out_item_t out_r;
  logic [255:0] in_pay;
  logic [15:0]  el_inc;

  assign in_pay = {in_data.payload_w3, in_data.payload_w2,
                   in_data.payload_w1, in_data.payload_w0};
  assign el_inc = (elapsed_r == 16'hffff) ? elapsed_r : elapsed_r + 16'd1;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign msg = ((op_r == ksca_pkg::OP_RESPONSE) ? chal_r : pay_r) ^ key;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      ST_IDLE: if (in_valid && in_ready &&
                   (in_data.op == ksca_pkg::OP_CHALLENGE ||
                    (in_data.op == ksca_pkg::OP_RESPONSE && link_r))) begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        state_nxt = ST_HASH;
      end
      ST_HASH: begin
        cmd.round = 1'b1;
        if (sts.last_round) state_nxt = ST_DONE;
      end
      ST_DONE: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      auth_r <= 1'b0;
      link_r <= 1'b0;
      elapsed_r <= '0;
      chal_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (in_valid && in_ready) begin
        op_r  <= in_data.op;
        pay_r <= in_pay;
        out_r <= '0;
        case (in_data.op)
          ksca_pkg::OP_CONNECT: begin
            chal_r <= in_pay; auth_r <= 1'b0; link_r <= 1'b1; elapsed_r <= '0;
            out_r.is_authenticated <= 1'b0; out_valid_r <= 1'b1;
          end
          ksca_pkg::OP_RESPONSE: begin
            out_r.is_authenticated <= auth_r;
            if (!link_r) out_valid_r <= 1'b1;
          end
          ksca_pkg::OP_CHALLENGE: out_r.is_authenticated <= auth_r;
          ksca_pkg::OP_TICK: begin
            out_r.is_authenticated <= auth_r;
            out_valid_r <= 1'b1;
            if (link_r && !auth_r) begin
              if (el_inc >= timeout) begin
                out_r.drop_link <= 1'b1; link_r <= 1'b0; elapsed_r <= '0;
              end else begin
                elapsed_r <= el_inc;
              end
            end
          end
          ksca_pkg::OP_DISCONNECT: begin
            link_r <= 1'b0; elapsed_r <= '0;
            out_r.is_authenticated <= auth_r; out_valid_r <= 1'b1;
          end
          default: begin
            out_r.is_authenticated <= auth_r; out_valid_r <= 1'b1;
          end
        endcase
      end
      if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        if (op_r == ksca_pkg::OP_CHALLENGE) begin
          {out_r.digest_w3, out_r.digest_w2, out_r.digest_w1, out_r.digest_w0} <= digest;
        end else if (digest == pay_r) begin
          auth_r <= 1'b1;
          out_r.is_authenticated <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("input taken while hashing");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HASH && sts.last_round) |=> (state_r == ST_DONE))
    else $error("hash did not finish");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.drop_link) |-> !out_r.is_authenticated)
    else $error("drop while authenticated");

endmodule
`default_nettype wire

// File: rtl/keyed_sha256_challenge_auth_core.sv
// Connect, tick, disconnect and ignored items give their result in the cycle
// after they are taken; a challenge, or a response while the link is up, is hashed.
// Throughput: one item at a time; a hash item runs the load, hash and done states,
// the hash state running the 64 rounds of the single shared SHA-256 round unit.
// Reset: synchronous active-low rst_n clears key, state and link; timeout 10000.
`default_nettype none
module keyed_sha256_challenge_auth_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ksca_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ksca_pkg::out_item_t       out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [63:0]          cfg_data
);

  logic [63:0] key_r [4];
  logic [15:0] timeout_r;
  ksca_pkg::dp_cmd_t cmd;
  ksca_pkg::dp_sts_t sts;
  logic [255:0] msg, digest;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      timeout_r <= ksca_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ksca_pkg::CFG_KEY0: key_r[0] <= cfg_data;
        ksca_pkg::CFG_KEY1: key_r[1] <= cfg_data;
        ksca_pkg::CFG_KEY2: key_r[2] <= cfg_data;
        ksca_pkg::CFG_KEY3: key_r[3] <= cfg_data;
        ksca_pkg::CFG_TIMEOUT: timeout_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ksca_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .key({key_r[3], key_r[2], key_r[1], key_r[0]}),
    .timeout(timeout_r), .cmd, .msg, .sts, .digest
  );

  ksca_sha_dp u_dp (
    .clk, .cmd, .msg, .sts, .digest
  );

endmodule
`default_nettype wire
